// ----- rtl/nsrb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package nsrb_pkg;

	// request and reply framing
	localparam int REPLY_BYTES = 48;
	localparam int COUNT_W     = 6;
	localparam int ORIG_BYTES  = 8;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;

	localparam logic [COUNT_W-1:0] COUNT_SAT      = 6'd49;
	localparam logic [COUNT_W-1:0] ORIG_FIRST     = 6'd40;
	localparam logic [COUNT_W-1:0] LAST_REQ_IDX   = 6'd47;
	localparam logic [COUNT_W-1:0] LAST_REPLY_IDX = 6'd47;

	// LI 0, version 3, mode 4 (server)
	localparam logic [7:0] MODE_BYTE = 8'h1C;

	// clock conversion
	localparam logic [31:0] NTP_EPOCH_DELTA = 32'd2208988800;
	localparam logic [19:0] MICROS_MAX      = 20'd999999;

	// fraction = floor(us * 2^26 / 15625) = us * FRAC_INT + floor(us * FRAC_REM / 15625)
	// the second term is a reciprocal multiply, exact for us below one million
	localparam int unsigned FRAC_DEN   = 15625;
	localparam int unsigned FRAC_INT   = (1 << 26) / FRAC_DEN;
	localparam int unsigned FRAC_REM   = (1 << 26) - FRAC_INT * FRAC_DEN;
	localparam int          FRAC_SHIFT = 34;
	localparam int          FRAC_MUL_W = 34;
	localparam logic [12:0] FRAC_INT_W = 13'(FRAC_INT);
	localparam logic [FRAC_MUL_W-1:0] FRAC_MUL = FRAC_MUL_W'(
		((64'(FRAC_REM) << FRAC_SHIFT) + 64'(FRAC_DEN - 1)) / 64'(FRAC_DEN));

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_UTC_OFFSET  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STRATUM     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POLL        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PRECISION   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROOT_DISP   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REFERENCE   = 3'd5;

	// register reset values
	localparam logic [16:0] RST_UTC_OFFSET = 17'd28800;
	localparam logic [3:0]  RST_STRATUM    = 4'd1;
	localparam logic [4:0]  RST_POLL       = 5'd4;
	localparam logic [7:0]  RST_PRECISION  = 8'hF7;
	localparam logic [31:0] RST_ROOT_DISP  = 32'h0000_0050;
	localparam logic [31:0] RST_REFERENCE  = 32'h4750_5300;

	typedef struct packed {
		logic [16:0] utc_offset;
		logic [3:0]  stratum;
		logic [4:0]  poll;
		logic [7:0]  precision;
		logic [31:0] root_disp;
		logic [31:0] reference_id;
	} cfg_t;

	// one accepted full-length request, pulse on valid, payload held until the next
	typedef struct packed {
		logic                        valid;
		logic [31:0]                 secs;
		logic [19:0]                 micros;
		logic [ORIG_BYTES-1:0][7:0]  orig;
	} trig_t;

	typedef struct packed {
		logic [31:0] secs;
		logic [31:0] frac;
	} stamp_t;

endpackage

`default_nettype wire

// ----- rtl/nsrb_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface nsrb_req_if;
	logic        valid;
	logic        ready;
	logic [7:0]  req_byte;
	logic        req_last;
	logic [31:0] unix_seconds;
	logic [19:0] clock_micros;

	modport source (
		output valid, req_byte, req_last, unix_seconds, clock_micros,
		input  ready
	);
	modport sink (
		input  valid, req_byte, req_last, unix_seconds, clock_micros,
		output ready
	);
endinterface

`default_nettype wire

// ----- rtl/nsrb_resp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface nsrb_resp_if;
	logic       valid;
	logic       ready;
	logic [7:0] resp_byte;
	logic       resp_last;

	modport source (
		output valid, resp_byte, resp_last,
		input  ready
	);
	modport sink (
		input  valid, resp_byte, resp_last,
		output ready
	);
endinterface

`default_nettype wire

// ----- rtl/nsrb_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nsrb_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [nsrb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [nsrb_pkg::CFG_DATA_W-1:0] cfg_data,
	output nsrb_pkg::cfg_t                      cfg
);
	import nsrb_pkg::*;

	cfg_t cfg_q;

	// register file, writes to unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.utc_offset   <= RST_UTC_OFFSET;
			cfg_q.stratum      <= RST_STRATUM;
			cfg_q.poll         <= RST_POLL;
			cfg_q.precision    <= RST_PRECISION;
			cfg_q.root_disp    <= RST_ROOT_DISP;
			cfg_q.reference_id <= RST_REFERENCE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_UTC_OFFSET: cfg_q.utc_offset   <= cfg_data[16:0];
				REG_STRATUM:    cfg_q.stratum      <= cfg_data[3:0];
				REG_POLL:       cfg_q.poll         <= cfg_data[4:0];
				REG_PRECISION:  cfg_q.precision    <= cfg_data[7:0];
				REG_ROOT_DISP:  cfg_q.root_disp    <= cfg_data[31:0];
				REG_REFERENCE:  cfg_q.reference_id <= cfg_data[31:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/nsrb_ingest.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nsrb_ingest (
	input  wire logic      clk,
	input  wire logic      arst_n,
	nsrb_req_if.sink       req,
	input  wire logic      tx_busy,
	output nsrb_pkg::trig_t trig
);
	import nsrb_pkg::*;

	logic [COUNT_W-1:0] count_q;
	logic [7:0]         orig_q [ORIG_BYTES];

	logic               good;
	logic               accept;
	logic [19:0]        micros_sat;

	logic                       trig_vld_s1;
	logic [31:0]                secs_s1;
	logic [19:0]                micros_s1;
	logic [ORIG_BYTES-1:0][7:0] orig_s1;

	// a last beat that completes 48 bytes starts a reply; it waits while one is loading
	assign good       = req.req_last && (count_q == LAST_REQ_IDX);
	assign req.ready  = !(good && tx_busy);
	assign accept     = req.valid && req.ready;
	assign micros_sat = (req.clock_micros > MICROS_MAX) ? MICROS_MAX : req.clock_micros;

	// byte counter, saturating, cleared by the last beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (req.req_last) begin
				count_q <= '0;
			end else if (count_q < COUNT_SAT) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// client transmit time, request bytes 40..47 (40 is a multiple of 8)
	always_ff @(posedge clk) begin
		if (accept && (count_q >= ORIG_FIRST) && (count_q <= LAST_REQ_IDX)) begin
			orig_q[count_q[2:0]] <= req.req_byte;
		end
	end

	// trigger pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_vld_s1 <= 1'b0;
		end else begin
			trig_vld_s1 <= accept && good;
		end
	end

	// clock sample and originate snapshot, the final byte comes straight from the beat
	always_ff @(posedge clk) begin
		if (accept && good) begin
			secs_s1   <= req.unix_seconds;
			micros_s1 <= micros_sat;
			for (int i = 0; i < ORIG_BYTES - 1; i++) begin
				orig_s1[i] <= orig_q[i];
			end
			orig_s1[ORIG_BYTES-1] <= req.req_byte;
		end
	end

	always_comb begin
		trig.valid  = trig_vld_s1;
		trig.secs   = secs_s1;
		trig.micros = micros_s1;
		trig.orig   = orig_s1;
	end

endmodule

`default_nettype wire

// ----- rtl/nsrb_stamp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nsrb_stamp (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire nsrb_pkg::trig_t  trig,
	input  wire nsrb_pkg::cfg_t   cfg,
	output nsrb_pkg::stamp_t      stamp
);
	import nsrb_pkg::*;

	logic [FRAC_SHIFT+19:0] prod_lo;

	logic        vld_s2;
	logic [31:0] secs_s2;
	logic [31:0] prod_int_s2;
	logic [19:0] prod_frac_s2;
	logic [31:0] frac_s3;

	assign prod_lo = (FRAC_SHIFT + 20)'(trig.micros) * FRAC_MUL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= trig.valid;
		end
	end

	// era seconds with the offset removed, plus the two fraction partial products
	always_ff @(posedge clk) begin
		if (trig.valid) begin
			secs_s2      <= trig.secs + NTP_EPOCH_DELTA
			                - {{15{cfg.utc_offset[16]}}, cfg.utc_offset};
			prod_int_s2  <= 32'(trig.micros * FRAC_INT_W);
			prod_frac_s2 <= prod_lo[FRAC_SHIFT+19:FRAC_SHIFT];
		end
	end

	// fraction sum
	always_ff @(posedge clk) begin
		if (vld_s2) begin
			frac_s3 <= prod_int_s2 + {12'd0, prod_frac_s2};
		end
	end

	assign stamp.secs = secs_s2;
	assign stamp.frac = frac_s3;

endmodule

`default_nettype wire

// ----- rtl/nsrb_reply_tx.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nsrb_reply_tx (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire nsrb_pkg::trig_t  trig,
	input  wire nsrb_pkg::stamp_t stamp,
	input  wire nsrb_pkg::cfg_t   cfg,
	nsrb_resp_if.source           resp,
	output logic                  tx_busy
);
	import nsrb_pkg::*;

	logic               busy_q;
	logic [COUNT_W-1:0] idx_q;
	logic               out_vld_q;
	logic [7:0]         out_byte_q;
	logic               out_last_q;

	logic               load;
	logic [7:0]         pkt [REPLY_BYTES];

	// reply layout, timestamps big endian
	always_comb begin
		pkt[0] = MODE_BYTE;
		pkt[1] = {4'd0, cfg.stratum};
		pkt[2] = {3'd0, cfg.poll};
		pkt[3] = cfg.precision;
		for (int i = 0; i < 4; i++) begin
			pkt[4 + i]  = 8'd0;
			pkt[8 + i]  = cfg.root_disp[31 - 8 * i -: 8];
			pkt[12 + i] = cfg.reference_id[31 - 8 * i -: 8];
			pkt[16 + i] = stamp.secs[31 - 8 * i -: 8];
			pkt[20 + i] = stamp.frac[31 - 8 * i -: 8];
			pkt[32 + i] = stamp.secs[31 - 8 * i -: 8];
			pkt[36 + i] = stamp.frac[31 - 8 * i -: 8];
			pkt[40 + i] = stamp.secs[31 - 8 * i -: 8];
			pkt[44 + i] = stamp.frac[31 - 8 * i -: 8];
		end
		for (int i = 0; i < ORIG_BYTES; i++) begin
			pkt[24 + i] = trig.orig[i];
		end
	end

	// next byte moves into the output register when it is empty or being taken
	assign load = busy_q && (!out_vld_q || resp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (trig.valid) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (load) begin
			if (idx_q == LAST_REPLY_IDX) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_q + 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load) begin
			out_vld_q <= 1'b1;
		end else if (resp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= pkt[idx_q];
			out_last_q <= (idx_q == LAST_REPLY_IDX);
		end
	end

	assign resp.valid     = out_vld_q;
	assign resp.resp_byte = out_byte_q;
	assign resp.resp_last = out_last_q;
	assign tx_busy        = busy_q;

endmodule

`default_nettype wire

// ----- rtl/ntp_server_reply_builder_unit.sv -----
// Takes one request byte per cycle, except while the last byte of a full request is held back.
// The taken last byte of a full 48-byte request sets the trigger register, which starts
// the reply sequencer; the reply then leaves one byte per cycle while the receiver takes
// each byte, through a single output register. The last byte of a full request waits while
// the previous reply is still being loaded. Reset clears the byte counter, the reply
// sequencer and the output valid, and loads the register defaults; the client time store
// holds no value until written.
`timescale 1ns / 1ps
`default_nettype none

module ntp_server_reply_builder_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	nsrb_req_if.sink                             req,
	nsrb_resp_if.source                          resp,
	input  wire logic                            cfg_we,
	input  wire logic [nsrb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [nsrb_pkg::CFG_DATA_W-1:0] cfg_data
);
	import nsrb_pkg::*;

	cfg_t   cfg;
	trig_t  trig;
	stamp_t stamp;
	logic   tx_busy;

	nsrb_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	nsrb_ingest u_ingest (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.tx_busy (tx_busy),
		.trig    (trig)
	);

	nsrb_stamp u_stamp (
		.clk    (clk),
		.arst_n (arst_n),
		.trig   (trig),
		.cfg    (cfg),
		.stamp  (stamp)
	);

	nsrb_reply_tx u_tx (
		.clk     (clk),
		.arst_n  (arst_n),
		.trig    (trig),
		.stamp   (stamp),
		.cfg     (cfg),
		.resp    (resp),
		.tx_busy (tx_busy)
	);

	// a new reply never starts on top of one still loading
	a_trig_idle: assert property (@(posedge clk) disable iff (!arst_n)
		trig.valid |-> !tx_busy)
		else $error("reply started while previous reply still loading");

	// a trigger always starts the sequencer
	a_trig_busy: assert property (@(posedge clk) disable iff (!arst_n)
		trig.valid |=> tx_busy)
		else $error("trigger did not start reply sequencer");

	// a reply beat that is not taken stays put
	a_hold_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(resp.valid && !resp.ready) |=>
		(resp.valid && $stable(resp.resp_byte) && $stable(resp.resp_last)))
		else $error("reply beat changed while waiting");

endmodule

`default_nettype wire
